@@ rtl/core/kf4_pkg.sv @@
// ----------------------------------------------------------------------------
// kf4_pkg
// shared constants, register indexes and fixed-point helpers of the
// four-state constant-velocity kalman filter
// ----------------------------------------------------------------------------
package kf4_pkg;

    localparam int STATE_COUNT_DEF = 4;
    localparam int FRAC_BITS_DEF   = 20;
    localparam int IO_COUNT        = 4;
    localparam int DATA_W          = 32;
    localparam int CFG_W           = 31;
    localparam int CFG_IDX_W       = 3;
    localparam int DT_W            = 21;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE_0  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE_1  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE_2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE_3  = 3'd5;

    localparam logic [DT_W-1:0]  DT_RESET = 21'd1049;
    localparam logic [CFG_W-1:0] Q_RESET  = 31'd10486;

    typedef logic signed [63:0] t_wide;
    typedef logic [DATA_W-1:0]  t_word;

    function automatic t_wide sx(input t_word v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic t_word sat32(input t_wide v);
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            return 32'h7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

@@ rtl/core/kf4_mul.sv @@
// ----------------------------------------------------------------------------
// kf4_mul
// shared signed 32x32 multiplier, product registered, rounded to the
// fraction width on the way out
// ----------------------------------------------------------------------------
module kf4_mul import kf4_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic  i_clk,
    input  t_word i_a,
    input  t_word i_b,
    output t_wide o_rnd
);

    localparam t_wide HALF = t_wide'(64'(1) << (FRAC_BITS - 1));

    t_wide r_p;

    always_ff @(posedge i_clk) begin
        r_p <= sx(i_a) * sx(i_b);
    end

    // arithmetic shift gives floor
    assign o_rnd = (r_p + HALF) >>> FRAC_BITS;

endmodule

@@ rtl/core/kf4_div.sv @@
// ----------------------------------------------------------------------------
// kf4_div
// iterative restoring divider, one quotient bit per cycle:
// sat32((a << FRAC_BITS) / b), truncated toward zero
// ----------------------------------------------------------------------------
module kf4_div import kf4_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_num,
    input  t_word i_den,
    output logic  o_done,
    output t_word o_quo
);

    localparam int NW = DATA_W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [32:0]   r_rem;
    logic [NW-1:0] r_quo;
    logic [31:0]   r_den;
    logic          r_neg;

    logic [31:0]   num_mag;
    logic [31:0]   den_mag;
    logic [32:0]   shifted;
    logic [32:0]   trial;
    t_wide         q_ext;

    assign num_mag = i_num[31] ? (32'd0 - i_num) : i_num;
    assign den_mag = i_den[31] ? (32'd0 - i_den) : i_den;
    assign shifted = {r_rem[31:0], r_quo[NW-1]};
    assign trial   = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= {num_mag, {FRAC_BITS{1'b0}}};
            r_den <= den_mag;
            r_neg <= i_num[31] ^ i_den[31];
        end else if (r_busy) begin
            if (!trial[32]) begin
                r_rem <= trial;
                r_quo <= {r_quo[NW-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_quo <= {r_quo[NW-2:0], 1'b0};
            end
        end
    end

    assign q_ext  = r_neg ? (64'sd0 - t_wide'(r_quo)) : t_wide'(r_quo);
    assign o_quo  = sat32(q_ext);
    assign o_done = r_done;

endmodule

@@ rtl/core/kf4_mem.sv @@
// ----------------------------------------------------------------------------
// kf4_mem
// scratch matrix memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
module kf4_mem import kf4_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_word         i_wdata,
    input  logic [AW-1:0] i_raddr0,
    input  logic [AW-1:0] i_raddr1,
    output t_word         o_rdata0,
    output t_word         o_rdata1
);

    t_word mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= mem[i_raddr0];
        o_rdata1 <= mem[i_raddr1];
    end

endmodule

@@ rtl/core/kalman_filter_4_state_unit.sv @@
// ----------------------------------------------------------------------------
// kalman_filter_4_state_unit
// the run time per measurement is set by the shared divider (2*N^2
// quotients) and the shared multiplier (four N x N matrix products)
// flow: one transaction at a time; a new one is taken while a result waits
// reset: synchronous, then a clearing pass over all 9*N*N words zeroes state and P
// ----------------------------------------------------------------------------
module kalman_filter_4_state_unit import kf4_pkg::*; #(
    parameter int STATE_COUNT = STATE_COUNT_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [31:0]          i_meas_0,
    input  logic [31:0]          i_meas_1,
    input  logic [31:0]          i_meas_2,
    input  logic [31:0]          i_meas_3,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [31:0]          o_est_0,
    output logic [31:0]          o_est_1,
    output logic [31:0]          o_est_2,
    output logic [31:0]          o_est_3,
    output logic                 o_singular,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int N     = STATE_COUNT;
    localparam int N2    = N * N;
    localparam int NRG   = 9;
    localparam int DEPTH = NRG * N2;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(N);
    localparam int JW    = $clog2(2 * N);
    localparam int XD    = (N > IO_COUNT) ? N : IO_COUNT;
    localparam t_word ONE = t_word'(64'(1) << FRAC_BITS);

    // memory regions
    localparam int RG_P   = 0;
    localparam int RG_PP  = 1;
    localparam int RG_T   = 2;
    localparam int RG_S   = 3;
    localparam int RG_INV = 4;
    localparam int RG_K   = 5;
    localparam int RG_X   = 6;
    localparam int RG_XP  = 7;
    localparam int RG_Y   = 8;

    // phases
    localparam logic [4:0] PH_CLR  = 5'd0;
    localparam logic [4:0] PH_IDLE = 5'd1;
    localparam logic [4:0] PH_XP   = 5'd2;
    localparam logic [4:0] PH_AP   = 5'd3;
    localparam logic [4:0] PH_PP   = 5'd4;
    localparam logic [4:0] PH_INIT = 5'd5;
    localparam logic [4:0] PH_PIV  = 5'd6;
    localparam logic [4:0] PH_SWP  = 5'd7;
    localparam logic [4:0] PH_PV   = 5'd8;
    localparam logic [4:0] PH_DIV  = 5'd9;
    localparam logic [4:0] PH_ELM  = 5'd10;
    localparam logic [4:0] PH_K    = 5'd11;
    localparam logic [4:0] PH_Y    = 5'd12;
    localparam logic [4:0] PH_X    = 5'd13;
    localparam logic [4:0] PH_P    = 5'd14;
    localparam logic [4:0] PH_CPX  = 5'd15;
    localparam logic [4:0] PH_CPP  = 5'd16;
    localparam logic [4:0] PH_FIN  = 5'd17;

    // steps within a phase
    localparam logic [3:0] SB_RD  = 4'd0;
    localparam logic [3:0] SB_EX  = 4'd1;
    localparam logic [3:0] SB_AC  = 4'd2;
    localparam logic [3:0] SB_WR  = 4'd3;
    localparam logic [3:0] SB_WR2 = 4'd4;
    localparam logic [3:0] SB_BI  = 4'd5;
    localparam logic [3:0] SB_BR  = 4'd6;
    localparam logic [3:0] SB_BC  = 4'd7;
    localparam logic [3:0] SB_DW  = 4'd8;

    logic [4:0]          r_ph, n_ph;
    logic [3:0]          r_sb, n_sb;
    logic [IW-1:0]       r_i, n_i;
    logic [JW-1:0]       r_j, n_j;
    logic [IW-1:0]       r_k, n_k;
    logic [IW-1:0]       r_c, n_c;
    logic [IW-1:0]       r_best, n_best;
    logic signed [33:0]  r_bmag, n_bmag;
    logic [AW-1:0]       r_clr, n_clr;
    t_wide               r_acc, n_acc;
    t_word               r_d0, n_d0;
    t_word               r_m, n_m;
    t_word               r_piv, n_piv;
    logic                r_sing, n_sing;
    logic                r_ov, n_ov;
    logic                r_osing, n_osing;
    t_word               r_z [XD];
    t_word               n_z [XD];
    t_word               r_xs [XD];
    t_word               n_xs [XD];
    t_word               r_out [IO_COUNT];
    t_word               n_out [IO_COUNT];
    logic [DT_W-1:0]     r_dt;
    logic [CFG_W-1:0]    r_q;
    logic [CFG_W-1:0]    r_rn [IO_COUNT];

    logic                we;
    logic [AW-1:0]       waddr, ra0, ra1;
    t_word               wdata, d0, d1;
    t_word               mul_a, mul_b;
    t_wide               rnd;
    logic                div_start, div_done;
    t_word               div_quo;

    logic [AW-1:0]       mac_ra0, mac_ra1, mac_wa;
    t_word               mac_a, mac_b;
    int                  mac_cols;
    logic [4:0]          mac_next;
    t_word               z_in [IO_COUNT];

    function automatic logic [AW-1:0] addr(input int rg, input int r, input int c);
        return AW'(rg * N2 + r * N + c);
    endfunction

    function automatic t_word gen_a(input int i, input int k);
        if (i == k) begin
            return ONE;
        end else if (i < N / 2 && k == i + N / 2) begin
            return {{(DATA_W - DT_W){1'b0}}, r_dt};
        end
        return '0;
    endfunction

    kf4_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 (ra0),
        .i_raddr1 (ra1),
        .o_rdata0 (d0),
        .o_rdata1 (d1)
    );

    kf4_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_rnd (rnd)
    );

    kf4_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (d0),
        .i_den   (r_piv),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign z_in[0] = i_meas_0;
    assign z_in[1] = i_meas_1;
    assign z_in[2] = i_meas_2;
    assign z_in[3] = i_meas_3;

    // operand routing of the matrix product phases
    always_comb begin
        int ii, jj, kk;
        ii = int'(r_i);
        jj = int'(r_j);
        kk = int'(r_k);
        mac_ra0  = '0;
        mac_ra1  = '0;
        mac_wa   = '0;
        mac_a    = d0;
        mac_b    = d1;
        mac_cols = N;
        mac_next = PH_FIN;
        unique case (r_ph)
            PH_XP: begin
                mac_ra1  = addr(RG_X, 0, kk);
                mac_a    = gen_a(ii, kk);
                mac_wa   = addr(RG_XP, 0, ii);
                mac_cols = 1;
                mac_next = PH_AP;
            end
            PH_AP: begin
                mac_ra1  = addr(RG_P, kk, jj);
                mac_a    = gen_a(ii, kk);
                mac_wa   = addr(RG_T, ii, jj);
                mac_next = PH_PP;
            end
            PH_PP: begin
                mac_ra0  = addr(RG_T, ii, kk);
                mac_b    = gen_a(jj, kk);
                mac_wa   = addr(RG_PP, ii, jj);
                mac_next = PH_INIT;
            end
            PH_K: begin
                mac_ra0  = addr(RG_PP, ii, kk);
                mac_ra1  = addr(RG_INV, kk, jj);
                mac_wa   = addr(RG_K, ii, jj);
                mac_next = PH_Y;
            end
            PH_X: begin
                mac_ra0  = addr(RG_K, ii, kk);
                mac_ra1  = addr(RG_Y, 0, kk);
                mac_wa   = addr(RG_X, 0, ii);
                mac_cols = 1;
                mac_next = PH_P;
            end
            PH_P: begin
                mac_ra0  = addr(RG_K, ii, kk);
                mac_ra1  = addr(RG_PP, kk, jj);
                mac_a    = sat32(sx((ii == kk) ? ONE : '0) - sx(d0));
                mac_wa   = addr(RG_P, ii, jj);
                mac_next = PH_FIN;
            end
            default: begin
                mac_cols = N;
            end
        endcase
    end

    always_comb begin
        int ii, jj, kk, cc, jc, jrg, ni;
        t_word pv, rsel;
        logic signed [33:0] mag;
        logic [IW-1:0] nb;
        logic signed [33:0] nm;
        logic adv;
        ii   = int'(r_i);
        jj   = int'(r_j);
        kk   = int'(r_k);
        cc   = int'(r_c);
        jc   = (jj < N) ? jj : jj - N;
        jrg  = (jj < N) ? RG_S : RG_INV;
        ni   = 0;
        pv   = sat32(r_acc);
        rsel = '0;
        mag  = '0;
        nb   = r_best;
        nm   = r_bmag;
        adv  = 1'b0;
        for (int k = 0; k < IO_COUNT; k++) begin
            if (ii == k) begin
                rsel = {1'b0, r_rn[k]};
            end
        end

        n_ph    = r_ph;
        n_sb    = r_sb;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_c     = r_c;
        n_best  = r_best;
        n_bmag  = r_bmag;
        n_clr   = r_clr;
        n_acc   = r_acc;
        n_d0    = r_d0;
        n_m     = r_m;
        n_piv   = r_piv;
        n_sing  = r_sing;
        n_ov    = r_ov;
        n_osing = r_osing;
        n_z     = r_z;
        n_xs    = r_xs;
        n_out   = r_out;
        we      = 1'b0;
        waddr   = '0;
        wdata   = '0;
        ra0     = '0;
        ra1     = '0;
        mul_a   = r_m;
        mul_b   = d1;
        div_start = 1'b0;

        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end

        unique case (r_ph)
            PH_CLR: begin
                we    = 1'b1;
                waddr = r_clr;
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_ph = PH_IDLE;
                end
            end
            PH_IDLE: begin
                if (i_valid) begin
                    for (int k = 0; k < XD; k++) begin
                        n_z[k] = (k < IO_COUNT) ? z_in[k] : '0;
                    end
                    n_ph   = PH_XP;
                    n_sb   = SB_RD;
                    n_i    = '0;
                    n_j    = '0;
                    n_k    = '0;
                    n_acc  = '0;
                    n_sing = 1'b0;
                end
            end
            PH_XP, PH_AP, PH_PP, PH_K, PH_X, PH_P: begin
                unique case (r_sb)
                    SB_RD: begin
                        ra0  = mac_ra0;
                        ra1  = mac_ra1;
                        n_sb = SB_EX;
                    end
                    SB_EX: begin
                        mul_a = mac_a;
                        mul_b = mac_b;
                        n_sb  = SB_AC;
                    end
                    SB_AC: begin
                        n_acc = r_acc + rnd;
                        if (kk == N - 1) begin
                            n_sb = (r_ph == PH_X) ? SB_BI : SB_WR;
                        end else begin
                            n_k  = r_k + 1'b1;
                            n_sb = SB_RD;
                        end
                    end
                    SB_BI: begin
                        ra0  = addr(RG_XP, 0, ii);
                        n_sb = SB_WR;
                    end
                    SB_WR: begin
                        we    = 1'b1;
                        waddr = mac_wa;
                        if (r_ph == PH_PP) begin
                            // process noise on the diagonal, then S in the next step
                            if (ii == jj) begin
                                pv = sat32(sx(sat32(r_acc)) + t_wide'(r_q));
                            end
                            n_d0 = pv;
                            n_sb = SB_WR2;
                        end else if (r_ph == PH_X) begin
                            pv = sat32(sx(d0) + sx(sat32(r_acc)));
                            n_xs[r_i] = pv;
                            adv = 1'b1;
                        end else begin
                            adv = 1'b1;
                        end
                        wdata = pv;
                    end
                    SB_WR2: begin
                        we    = 1'b1;
                        waddr = addr(RG_S, ii, jj);
                        wdata = (ii == jj) ? sat32(sx(r_d0) + sx(rsel)) : r_d0;
                        adv   = 1'b1;
                    end
                    default: begin
                        n_sb = SB_RD;
                    end
                endcase
                if (adv) begin
                    n_k   = '0;
                    n_acc = '0;
                    n_sb  = SB_RD;
                    if (jj == mac_cols - 1) begin
                        n_j = '0;
                        if (ii == N - 1) begin
                            n_i  = '0;
                            n_ph = mac_next;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            PH_INIT: begin
                we    = 1'b1;
                waddr = addr(RG_INV, ii, jj);
                wdata = (ii == jj) ? ONE : '0;
                if (jj == N - 1) begin
                    n_j = '0;
                    if (ii == N - 1) begin
                        n_ph   = PH_PIV;
                        n_sb   = SB_RD;
                        n_c    = '0;
                        n_i    = '0;
                        n_best = '0;
                        n_bmag = -34'sd1;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            PH_PIV: begin
                if (r_sb == SB_RD) begin
                    ra0  = addr(RG_S, ii, cc);
                    n_sb = SB_EX;
                end else begin
                    mag = d0[31] ? (34'sd0 - $signed({2'b11, d0})) : $signed({2'b00, d0});
                    // strict compare keeps the first row on ties
                    if (mag > r_bmag) begin
                        nb = r_i;
                        nm = mag;
                    end
                    n_best = nb;
                    n_bmag = nm;
                    n_sb   = SB_RD;
                    if (ii == N - 1) begin
                        n_j = '0;
                        if (nm == 34'sd0) begin
                            n_sing = 1'b1;
                            n_ph   = PH_CPX;
                            n_i    = '0;
                        end else if (nb != r_c) begin
                            n_ph = PH_SWP;
                        end else begin
                            n_ph = PH_PV;
                        end
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end
            end
            PH_SWP: begin
                unique case (r_sb)
                    SB_RD: begin
                        ra0  = addr(jrg, cc, jc);
                        ra1  = addr(jrg, int'(r_best), jc);
                        n_sb = SB_EX;
                    end
                    SB_EX: begin
                        we    = 1'b1;
                        waddr = addr(jrg, cc, jc);
                        wdata = d1;
                        n_d0  = d0;
                        n_sb  = SB_WR;
                    end
                    default: begin
                        we    = 1'b1;
                        waddr = addr(jrg, int'(r_best), jc);
                        wdata = r_d0;
                        n_sb  = SB_RD;
                        if (jj == 2 * N - 1) begin
                            n_j  = '0;
                            n_ph = PH_PV;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end
                endcase
            end
            PH_PV: begin
                if (r_sb == SB_RD) begin
                    ra0  = addr(RG_S, cc, cc);
                    n_sb = SB_EX;
                end else begin
                    n_piv = d0;
                    n_j   = '0;
                    n_sb  = SB_RD;
                    n_ph  = PH_DIV;
                end
            end
            PH_DIV: begin
                unique case (r_sb)
                    SB_RD: begin
                        ra0  = addr(jrg, cc, jc);
                        n_sb = SB_EX;
                    end
                    SB_EX: begin
                        div_start = 1'b1;
                        n_sb      = SB_DW;
                    end
                    default: begin
                        if (div_done) begin
                            we    = 1'b1;
                            waddr = addr(jrg, cc, jc);
                            wdata = div_quo;
                            n_sb  = SB_RD;
                            if (jj == 2 * N - 1) begin
                                n_j  = '0;
                                n_i  = (cc == 0) ? IW'(1) : '0;
                                n_sb = SB_BR;
                                n_ph = PH_ELM;
                            end else begin
                                n_j = r_j + 1'b1;
                            end
                        end
                    end
                endcase
            end
            PH_ELM: begin
                unique case (r_sb)
                    SB_BR: begin
                        ra0  = addr(RG_S, ii, cc);
                        n_sb = SB_BC;
                    end
                    SB_BC: begin
                        n_m  = d0;
                        n_j  = '0;
                        n_sb = SB_RD;
                    end
                    SB_RD: begin
                        ra0  = addr(jrg, ii, jc);
                        ra1  = addr(jrg, cc, jc);
                        n_sb = SB_EX;
                    end
                    SB_EX: begin
                        n_d0 = d0;
                        n_sb = SB_AC;
                    end
                    default: begin
                        we    = 1'b1;
                        waddr = addr(jrg, ii, jc);
                        wdata = sat32(sx(r_d0) - rnd);
                        n_sb  = SB_RD;
                        if (jj == 2 * N - 1) begin
                            n_j = '0;
                            ni  = ii + 1;
                            if (ni == cc) begin
                                ni = ni + 1;
                            end
                            if (ni < N) begin
                                n_i  = IW'(ni);
                                n_sb = SB_BR;
                            end else if (cc == N - 1) begin
                                n_i   = '0;
                                n_k   = '0;
                                n_acc = '0;
                                n_ph  = PH_K;
                            end else begin
                                n_c    = r_c + 1'b1;
                                n_i    = r_c + 1'b1;
                                n_best = r_c + 1'b1;
                                n_bmag = -34'sd1;
                                n_ph   = PH_PIV;
                            end
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end
                endcase
            end
            PH_Y, PH_CPX: begin
                if (r_sb == SB_RD) begin
                    ra0  = addr(RG_XP, 0, ii);
                    n_sb = SB_EX;
                end else begin
                    we   = 1'b1;
                    n_sb = SB_RD;
                    if (r_ph == PH_Y) begin
                        waddr = addr(RG_Y, 0, ii);
                        wdata = sat32(sx(r_z[r_i]) - sx(d0));
                    end else begin
                        waddr     = addr(RG_X, 0, ii);
                        wdata     = d0;
                        n_xs[r_i] = d0;
                    end
                    if (ii == N - 1) begin
                        n_i   = '0;
                        n_j   = '0;
                        n_k   = '0;
                        n_acc = '0;
                        n_ph  = (r_ph == PH_Y) ? PH_X : PH_CPP;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end
            end
            PH_CPP: begin
                if (r_sb == SB_RD) begin
                    ra0  = addr(RG_PP, ii, jj);
                    n_sb = SB_EX;
                end else begin
                    we    = 1'b1;
                    waddr = addr(RG_P, ii, jj);
                    wdata = d0;
                    n_sb  = SB_RD;
                    if (jj == N - 1) begin
                        n_j = '0;
                        if (ii == N - 1) begin
                            n_i  = '0;
                            n_ph = PH_FIN;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            PH_FIN: begin
                // hand over only once the previous transaction has left
                if (!r_ov || i_ready) begin
                    for (int k = 0; k < IO_COUNT; k++) begin
                        n_out[k] = (k < N) ? r_xs[k] : '0;
                    end
                    n_osing = r_sing;
                    n_ov    = 1'b1;
                    n_ph    = PH_IDLE;
                end
            end
            default: begin
                n_ph = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_CLR;
            r_sb   <= SB_RD;
            r_clr  <= '0;
            r_ov   <= 1'b0;
            r_sing <= 1'b0;
            r_i    <= '0;
            r_j    <= '0;
            r_k    <= '0;
            r_c    <= '0;
            r_dt   <= DT_RESET;
            r_q    <= Q_RESET;
            for (int k = 0; k < IO_COUNT; k++) begin
                r_rn[k] <= '0;
            end
        end else begin
            r_ph   <= n_ph;
            r_sb   <= n_sb;
            r_clr  <= n_clr;
            r_ov   <= n_ov;
            r_sing <= n_sing;
            r_i    <= n_i;
            r_j    <= n_j;
            r_k    <= n_k;
            r_c    <= n_c;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TIME_STEP:     r_dt    <= i_cfg_data[DT_W-1:0];
                    CFG_PROCESS_NOISE: r_q     <= i_cfg_data;
                    CFG_MEAS_NOISE_0:  r_rn[0] <= i_cfg_data;
                    CFG_MEAS_NOISE_1:  r_rn[1] <= i_cfg_data;
                    CFG_MEAS_NOISE_2:  r_rn[2] <= i_cfg_data;
                    CFG_MEAS_NOISE_3:  r_rn[3] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_best  <= n_best;
        r_bmag  <= n_bmag;
        r_acc   <= n_acc;
        r_d0    <= n_d0;
        r_m     <= n_m;
        r_piv   <= n_piv;
        r_osing <= n_osing;
        r_z     <= n_z;
        r_xs    <= n_xs;
        r_out   <= n_out;
    end

    assign o_ready    = (r_ph == PH_IDLE);
    assign o_valid    = r_ov;
    assign o_singular = r_osing;
    assign o_est_0    = r_out[0];
    assign o_est_1    = r_out[1];
    assign o_est_2    = r_out[2];
    assign o_est_3    = r_out[3];

endmodule

@@ rtl/core/kf4_chk.sv @@
// ----------------------------------------------------------------------------
// kf4_chk
// port-level checks of the kalman filter unit, bound to the top level
// ----------------------------------------------------------------------------
module kf4_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_est_0,
    input logic        o_singular
);

    // one transaction at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken while a transaction is in progress");

    // a fresh result always comes with the input side free again
    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> o_ready)
        else $error("result shown while still busy");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_est_0) && $stable(o_singular))
        else $error("stalled result changed");

    // clearing pass keeps both sides quiet after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready && !o_valid)
        else $error("activity right after reset");

endmodule

bind kalman_filter_4_state_unit kf4_chk u_kf4_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_est_0    (o_est_0),
    .o_singular (o_singular)
);
